>>> design/sld_pkg.sv
// ----------------------------------------------------------------------------
// sld_pkg: shared types and constants for the sync/length/checksum deframer
// Holds the configuration register indexes, the status codes and the record
// types passed between the parser core and the top level.
// ----------------------------------------------------------------------------
package sld_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned SUM_W      = 16;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned STATUS_W   = 3;
    localparam int unsigned OUT_DATA_W = 24;

    // The body is the length code plus this many bytes.
    localparam logic [BYTE_W-1:0] LENGTH_EXTRA    = 8'd7;
    // Largest code whose body total still fits in a byte.
    localparam logic [BYTE_W-1:0] LENGTH_CODE_CAP = 8'd248;

    localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'h5A;
    localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'hA5;
    localparam logic [BYTE_W-1:0] MAX_LEN_RST     = 8'd136;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SYNC_FIRST  = 2'd0,
        REG_SYNC_SECOND = 2'd1,
        REG_MAX_LENGTH  = 2'd2
    } t_cfg_reg;

    typedef enum logic [STATUS_W-1:0] {
        ST_HUNTING    = 3'd0,
        ST_FIRST_SYNC = 3'd1,
        ST_IN_BODY    = 3'd2,
        ST_FRAME_GOOD = 3'd3,
        ST_SUM_BAD    = 3'd4,
        ST_LEN_REJECT = 3'd5
    } t_status;

    typedef struct packed {
        logic [BYTE_W-1:0] sync_first;
        logic [BYTE_W-1:0] sync_second;
        logic [BYTE_W-1:0] max_length_code;
    } t_cfg;

    typedef struct packed {
        t_status           status;
        logic              body_valid;
        logic [BYTE_W-1:0] body_index;
        logic [BYTE_W-1:0] body_byte;
    } t_result;

endpackage

>>> design/sld_cfg_regs.sv
// ----------------------------------------------------------------------------
// sld_cfg_regs: configuration register file
// Three byte-wide registers written through a valid/ready channel. Writes to
// an index beyond the register list are accepted and dropped.
// ----------------------------------------------------------------------------
module sld_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_wr_en,
    input  logic [sld_pkg::CFG_IDX_W-1:0]  i_wr_index,
    input  logic [sld_pkg::BYTE_W-1:0]     i_wr_data,
    output sld_pkg::t_cfg                  o_cfg
);

    sld_pkg::t_cfg r_cfg;
    sld_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_en) begin
            unique case (i_wr_index)
                sld_pkg::REG_SYNC_FIRST:  n_cfg.sync_first      = i_wr_data;
                sld_pkg::REG_SYNC_SECOND: n_cfg.sync_second     = i_wr_data;
                sld_pkg::REG_MAX_LENGTH:  n_cfg.max_length_code = i_wr_data;
                default:                  n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_first      <= sld_pkg::SYNC_FIRST_RST;
            r_cfg.sync_second     <= sld_pkg::SYNC_SECOND_RST;
            r_cfg.max_length_code <= sld_pkg::MAX_LEN_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> design/sld_parser.sv
// ----------------------------------------------------------------------------
// sld_parser: frame parser core
// Holds the hunt and body state and works out the result for one byte.
// State advances only on cycles where i_step is high.
// ----------------------------------------------------------------------------
module sld_parser (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_step,
    input  logic [sld_pkg::BYTE_W-1:0] i_byte,
    input  sld_pkg::t_cfg              i_cfg,
    output sld_pkg::t_result           o_result
);

    logic                       r_first_seen, n_first_seen;
    logic                       r_in_body,    n_in_body;
    logic [sld_pkg::BYTE_W-1:0] r_position,   n_position;
    logic [sld_pkg::BYTE_W-1:0] r_total,      n_total;
    logic [sld_pkg::SUM_W-1:0]  r_sum,        n_sum;
    logic [sld_pkg::BYTE_W-1:0] r_prev,       n_prev;

    logic                       len_reject;
    logic [sld_pkg::BYTE_W-1:0] eff_total;
    logic [sld_pkg::BYTE_W:0]   pos_p1;
    logic [sld_pkg::BYTE_W:0]   pos_p2;
    logic [sld_pkg::SUM_W-1:0]  trailer;

    assign len_reject = (i_byte > i_cfg.max_length_code) ||
                        (i_byte > sld_pkg::LENGTH_CODE_CAP);
    // At the length byte the new total is used straight away.
    assign eff_total  = (r_position == '0) ? (i_byte + sld_pkg::LENGTH_EXTRA) : r_total;
    assign pos_p1     = {1'b0, r_position} + 9'd1;
    assign pos_p2     = {1'b0, r_position} + 9'd2;
    // Trailer is little-endian: the byte before the last is the low half.
    assign trailer    = {i_byte, r_prev};

    always_comb begin
        n_first_seen = r_first_seen;
        n_in_body    = r_in_body;
        n_position   = r_position;
        n_total      = r_total;
        n_sum        = r_sum;
        n_prev       = r_prev;
        o_result     = '0;

        if (r_in_body) begin
            if (r_position == '0 && len_reject) begin
                n_first_seen    = 1'b0;
                n_in_body       = 1'b0;
                n_position      = '0;
                n_sum           = '0;
                o_result.status = sld_pkg::ST_LEN_REJECT;
            end else begin
                n_total             = eff_total;
                n_prev              = i_byte;
                o_result.body_byte  = i_byte;
                o_result.body_index = r_position;
                o_result.body_valid = 1'b1;
                if (pos_p1 >= {1'b0, eff_total}) begin
                    o_result.status = (~r_sum == trailer) ? sld_pkg::ST_FRAME_GOOD
                                                          : sld_pkg::ST_SUM_BAD;
                    n_first_seen    = 1'b0;
                    n_in_body       = 1'b0;
                    n_position      = '0;
                    n_sum           = '0;
                end else begin
                    if (pos_p2 < {1'b0, eff_total}) begin
                        n_sum = r_sum + {8'd0, i_byte};
                    end
                    n_position      = pos_p1[sld_pkg::BYTE_W-1:0];
                    o_result.status = sld_pkg::ST_IN_BODY;
                end
            end
        end else if (!r_first_seen && i_byte == i_cfg.sync_first) begin
            n_first_seen    = 1'b1;
            o_result.status = sld_pkg::ST_FIRST_SYNC;
        end else if (r_first_seen && i_byte == i_cfg.sync_second) begin
            n_in_body       = 1'b1;
            n_position      = '0;
            n_sum           = '0;
            o_result.status = sld_pkg::ST_IN_BODY;
        end else begin
            n_first_seen    = 1'b0;
            n_in_body       = 1'b0;
            n_position      = '0;
            n_sum           = '0;
            o_result.status = sld_pkg::ST_HUNTING;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_seen <= 1'b0;
            r_in_body    <= 1'b0;
            r_position   <= '0;
            r_total      <= '0;
            r_sum        <= '0;
            r_prev       <= '0;
        end else if (i_step) begin
            r_first_seen <= n_first_seen;
            r_in_body    <= n_in_body;
            r_position   <= n_position;
            r_total      <= n_total;
            r_sum        <= n_sum;
            r_prev       <= n_prev;
        end
    end

endmodule

>>> design/sync_length_checksum_deframer.sv
// A byte is taken into the input register and then parsed into the result register.
// Throughput: one byte per cycle while the result word is not held back by m_axis_tready.
// The input register and the result register both advance whenever the
// result register is empty or its word is being taken.
// Reset (synchronous, active low) empties both registers, puts the parser
// back to hunting and loads the default sync and length limit registers.
// ----------------------------------------------------------------------------
// sync_length_checksum_deframer: sync/length/checksum frame parser
// Hunts for a two-byte sync, then echoes each body byte with its index and
// reports the frame as good, checksum bad or length rejected.
// ----------------------------------------------------------------------------
module sync_length_checksum_deframer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Configuration write channel.
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [sld_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sld_pkg::BYTE_W-1:0]     i_cfg_data,
    // Received bytes.
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [sld_pkg::BYTE_W-1:0]     s_axis_tdata,  // [7:0] rx_byte
    // Results.
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [7:0] body_byte, [15:8] body_index, [16] body_valid, [19:17] status,
    // [23:20] zero
    output logic [sld_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    sld_pkg::t_cfg              cfg;
    sld_pkg::t_result           result;
    logic                       advance;
    logic                       step;

    logic                       r_in_valid;
    logic [sld_pkg::BYTE_W-1:0] r_in_byte;
    logic                       r_out_valid;
    sld_pkg::t_result           r_out_result;

    assign o_cfg_ready = 1'b1;

    sld_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    assign advance       = !r_out_valid || m_axis_tready;
    assign step          = advance && r_in_valid;
    assign s_axis_tready = !r_in_valid || advance;

    sld_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_byte   (r_in_byte),
        .i_cfg    (cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
        end
        if (step) begin
            r_out_result <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, r_out_result};

endmodule
